@@ rtl/core/swept_decaying_tone_generator_macros.svh @@
// ---------------------------------------------------------------------------
// Swept decaying tone generator: assertion macros
// Shared property forms for the tone generator checks.
// ---------------------------------------------------------------------------
`ifndef SWEPT_DECAYING_TONE_GENERATOR_MACROS_SVH
`define SWEPT_DECAYING_TONE_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDTG_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDTG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/sdtg_pkg.sv @@
// ---------------------------------------------------------------------------
// sdtg_pkg
// Types, register codes and the quarter-wave sine table of the tone generator.
// ---------------------------------------------------------------------------
package sdtg_pkg;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_WIDTH      = 32;

  localparam int TAB_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int QBITS    = TAB_BITS - 2;
  localparam int QDEPTH   = 1 << QBITS;
  localparam int QSTEP    = 65536 >> QBITS;

  // polynomial coefficients, Q30 odd series for sin(x*pi/2)
  localparam logic [63:0] CF1 = 64'd1686629713;
  localparam logic [63:0] CF3 = 64'd693598668;
  localparam logic [63:0] CF5 = 64'd85569306;
  localparam logic [63:0] CF7 = 64'd5026995;
  localparam logic [63:0] CF9 = 64'd172272;

  typedef enum logic [2:0] {
    REG_PHASE_STEP_START = 3'd0,
    REG_PHASE_STEP_DELTA = 3'd1,
    REG_ENVELOPE_START   = 3'd2,
    REG_ENVELOPE_STEP    = 3'd3,
    REG_SAMPLE_COUNT     = 3'd4,
    REG_CLICK_COUNT      = 3'd5,
    REG_CLICK_SWING      = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [31:0] phase_step_start;
    logic [31:0] phase_step_delta;
    logic [22:0] envelope_start;
    logic [22:0] envelope_step;
    logic [15:0] sample_count;
    logic [7:0]  click_count;
    logic [6:0]  click_swing;
  } cfg_t;

  // request leaving the sequencer
  typedef struct packed {
    logic                silent;
    logic                click;
    logic [7:0]          click_level;
    logic                fin;
    logic [TAB_BITS-1:0] k;
    logic [22:0]         amp;
  } tone_req_t;

  // request after the table lookup
  typedef struct packed {
    logic               silent;
    logic               click;
    logic [7:0]         click_level;
    logic               fin;
    logic signed [15:0] sine;
    logic [22:0]        amp;
  } mix_req_t;

  typedef logic [QDEPTH-1:0][14:0] qtab_t;

  // sin(x*pi/2), x in Q16 (0..65536), result Q15
  function automatic logic [14:0] quarter_sine(input logic [16:0] x);
    logic [63:0] xw;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] v;
    xw = {47'd0, x};
    x2 = (xw * xw) >> 16;
    p  = CF9;
    p  = CF7 - ((p * x2) >> 16);
    p  = CF5 - ((p * x2) >> 16);
    p  = CF3 - ((p * x2) >> 16);
    p  = CF1 - ((p * x2) >> 16);
    v  = (p * xw) >> 16;
    v  = (v + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return v[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int m = 0; m < QDEPTH; m++) begin
      t[m] = quarter_sine(17'(m * QSTEP));
    end
    return t;
  endfunction

  localparam qtab_t      QTAB      = build_qtab();
  localparam logic [14:0] QTAB_TOP = quarter_sine(17'd65536);

  // full-cycle sine from a table index via quarter-wave symmetry
  function automatic logic signed [15:0] sine_lookup(input logic [TAB_BITS-1:0] k);
    logic [1:0]       quad;
    logic [QBITS-1:0] j;
    logic [14:0]      mag;
    quad = k[TAB_BITS-1 -: 2];
    j    = k[QBITS-1:0];
    if (quad[0]) begin
      if (j == '0) mag = QTAB_TOP;
      else mag = QTAB[QBITS'(~j + 1'b1)];
    end else begin
      mag = QTAB[j];
    end
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

@@ rtl/core/sdtg_regs.sv @@
// ---------------------------------------------------------------------------
// sdtg_regs
// Configuration register file of the tone generator.
// ---------------------------------------------------------------------------
module sdtg_regs
  import sdtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step_start <= '0;
      cfg.phase_step_delta <= '0;
      cfg.envelope_start   <= 23'd6553600;
      cfg.envelope_step    <= '0;
      cfg.sample_count     <= '0;
      cfg.click_count      <= '0;
      cfg.click_swing      <= 7'd100;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_PHASE_STEP_START: cfg.phase_step_start <= cfg_data;
        REG_PHASE_STEP_DELTA: cfg.phase_step_delta <= cfg_data;
        REG_ENVELOPE_START:   cfg.envelope_start   <= cfg_data[22:0];
        REG_ENVELOPE_STEP:    cfg.envelope_step    <= cfg_data[22:0];
        REG_SAMPLE_COUNT:     cfg.sample_count     <= cfg_data[15:0];
        REG_CLICK_COUNT:      cfg.click_count      <= cfg_data[7:0];
        REG_CLICK_SWING:      cfg.click_swing      <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/sdtg_seq.sv @@
// ---------------------------------------------------------------------------
// sdtg_seq
// Sound sequencer: index, phase and envelope accumulators, first stage.
// ---------------------------------------------------------------------------
module sdtg_seq
  import sdtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      restart,
  input  logic      drain,
  output logic      req_valid,
  output tone_req_t req
);

  logic [15:0]            sample_index;
  logic [PHASE_WIDTH-1:0] phase_acc;
  logic [31:0]            phase_step;
  logic [22:0]            amplitude;
  logic                   playing;

  logic [15:0]            idx0;
  logic [PHASE_WIDTH-1:0] acc0;
  logic [31:0]            step0;
  logic [22:0]            amp0;
  logic                   play0;
  logic                   play1;
  logic                   fin;
  logic                   load;
  tone_req_t              req_next;

  assign in_stall = req_valid && !drain;
  assign load     = in_valid && !in_stall;

  always_comb begin
    idx0  = restart ? '0 : sample_index;
    acc0  = restart ? '0 : phase_acc;
    step0 = restart ? cfg.phase_step_start : phase_step;
    amp0  = restart ? cfg.envelope_start : amplitude;
    play0 = restart ? (cfg.sample_count != '0) : playing;
    play1 = play0 && (idx0 < cfg.sample_count);
    fin   = ({1'b0, idx0} + 17'd1) == {1'b0, cfg.sample_count};

    req_next.silent      = !play1;
    req_next.click       = idx0 < {8'd0, cfg.click_count};
    req_next.click_level = idx0[0] ? (8'd128 - {1'b0, cfg.click_swing})
                                   : (8'd128 + {1'b0, cfg.click_swing});
    req_next.fin         = play1 && fin;
    req_next.k           = acc0[PHASE_WIDTH-1 -: TAB_BITS];
    req_next.amp         = amp0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      phase_acc    <= '0;
      phase_step   <= '0;
      amplitude    <= '0;
      playing      <= 1'b0;
    end else if (load) begin
      if (play1) begin
        sample_index <= idx0 + 16'd1;
        phase_acc    <= acc0 + step0[PHASE_WIDTH-1:0];
        phase_step   <= step0 + cfg.phase_step_delta;
        amplitude    <= (amp0 > cfg.envelope_step) ? amp0 - cfg.envelope_step : '0;
        playing      <= !fin;
      end else begin
        sample_index <= idx0;
        phase_acc    <= acc0;
        phase_step   <= step0;
        amplitude    <= amp0;
        playing      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) req_valid <= 1'b0;
    else if (load) req_valid <= 1'b1;
    else if (drain) req_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) req <= req_next;
  end

endmodule

@@ rtl/core/sdtg_sine.sv @@
// ---------------------------------------------------------------------------
// sdtg_sine
// Sine table stage: quarter-wave lookup of the phase index.
// ---------------------------------------------------------------------------
module sdtg_sine
  import sdtg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  tone_req_t req,
  output logic      drain,
  input  logic      mix_take,
  output logic      mix_valid,
  output mix_req_t  mix
);

  mix_req_t mix_next;

  assign drain = !mix_valid || mix_take;

  always_comb begin
    mix_next.silent      = req.silent;
    mix_next.click       = req.click;
    mix_next.click_level = req.click_level;
    mix_next.fin         = req.fin;
    mix_next.sine        = sine_lookup(req.k);
    mix_next.amp         = req.amp;
  end

  always_ff @(posedge clk) begin
    if (rst) mix_valid <= 1'b0;
    else if (drain) mix_valid <= req_valid;
  end

  always_ff @(posedge clk) begin
    if (drain && req_valid) mix <= mix_next;
  end

endmodule

@@ rtl/core/sdtg_mix.sv @@
// ---------------------------------------------------------------------------
// sdtg_mix
// Envelope multiply, bias and clamp, silence/click select, into the output register.
// ---------------------------------------------------------------------------
module sdtg_mix
  import sdtg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       mix_valid,
  input  mix_req_t   mix,
  output logic       mix_take,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] sample,
  output logic       final_sample,
  output logic       active
);

  localparam logic signed [40:0] TONE_BIAS = 41'sd274877906944; // 128 in Q31

  logic signed [39:0] prod;
  logic signed [40:0] total;
  logic [7:0]         tone;
  logic [7:0]         sample_next;

  assign mix_take = !out_valid || !out_stall;

  always_comb begin
    prod  = mix.sine * $signed({1'b0, mix.amp});
    total = 41'(prod) + TONE_BIAS;
    if (total[40]) tone = 8'd0;
    else if (total[39]) tone = 8'd255;
    else tone = total[38:31];

    if (mix.silent) sample_next = 8'd128;
    else if (mix.click) sample_next = mix.click_level;
    else sample_next = tone;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (mix_take) out_valid <= mix_valid;
  end

  always_ff @(posedge clk) begin
    if (mix_take && mix_valid) begin
      sample       <= sample_next;
      final_sample <= mix.fin;
      active       <= !mix.silent;
    end
  end

endmodule

@@ rtl/core/swept_decaying_tone_generator.sv @@
// ---------------------------------------------------------------------------
// swept_decaying_tone_generator
// Chirp tone with linear decay envelope and leading clicks, one PCM sample
// per request.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / restart): each request produces one
//   8-bit sample; restart=1 starts the sound at sample zero, restart=0 moves
//   on by one sample. Output channel (out_valid / out_stall): sample,
//   final_sample on the last sample of the sound, active while it plays.
//   Idle or finished requests give 128 with active low.
//   Path to out_valid: request register, sine table register, then
//   multiply/clamp into the output register.
//   Throughput: one request per cycle while in_stall is low; the
//   phase/envelope accumulators close their loop in the request stage.
//   Stall: out_stall holds the output register; the three stages fill, and
//   in_stall rises only once all of them hold a request.
//   Reset (rst, synchronous): registers take their defaults (envelope_start
//   100.0, click_swing 100), the sound is idle, the pipeline is empty.
//   Config (cfg_write / cfg_index / cfg_data): write only while no request is
//   in flight; start values act at the next restart, the rest at once.
// ---------------------------------------------------------------------------
`include "swept_decaying_tone_generator_macros.svh"

module swept_decaying_tone_generator
  import sdtg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  sample,
  output logic        final_sample,
  output logic        active
);

  cfg_t      cfg;
  logic      req_valid;
  tone_req_t req;
  logic      drain;
  logic      mix_valid;
  mix_req_t  mix;
  logic      mix_take;

  // configuration registers
  sdtg_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // stage 1: accumulators advance on each accepted request while the sound plays
  sdtg_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .drain     (drain),
    .req_valid (req_valid),
    .req       (req)
  );

  // stage 2: sine table
  sdtg_sine u_sine (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .drain     (drain),
    .mix_take  (mix_take),
    .mix_valid (mix_valid),
    .mix       (mix)
  );

  // stage 3: envelope multiply, clamp, output register
  sdtg_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .mix_valid    (mix_valid),
    .mix          (mix),
    .mix_take     (mix_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .final_sample (final_sample),
    .active       (active)
  );

  // input backpressure only once every stage holds a request
  `SDTG_ASSERT_IMP(a_stall_full, clk, rst, in_stall, req_valid && mix_valid && out_valid && out_stall, "input stalled with a free stage")

  // silence carries the center value and never ends a sound
  `SDTG_ASSERT_IMP(a_silence, clk, rst, out_valid && !active, sample == 8'd128 && !final_sample, "inactive result not silent")

  // an accepted request with no stall anywhere reaches the sine stage
  `SDTG_ASSERT_NEXT(a_flow, clk, rst, in_valid && !in_stall, req_valid, "accepted request lost")

endmodule
